// File: rtl/rau_pkg.sv
// Package with operation codes and shared types for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_RED = 3'd4;
  localparam logic [2:0] KIND_RCP = 3'd5;

  typedef struct packed {
    logic start;
    logic done;
  } rau_ctl_t;
endpackage

// File: rtl/rau_divider.sv
// Bit-serial signed truncating divider giving quotient and remainder, one bit a cycle.
`timescale 1ns / 1ps
module rau_divider import rau_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output rau_ctl_t     ctl,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic         qn_r, qn_nxt, rn_r, rn_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]   trial;
  logic [W-1:0] rsh;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    qn_nxt = qn_r;
    rn_nxt = rn_r;
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    rsh = {r_r[W-2:0], q_r[W-1]};
    trial = {1'b0, rsh} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend[W-1] ? (~dividend + 1'b1) : dividend;
      d_nxt = divisor[W-1] ? (~divisor + 1'b1) : divisor;
      r_nxt = '0;
      qn_nxt = dividend[W-1] ^ divisor[W-1];
      rn_nxt = dividend[W-1];
      busy_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (busy_r) begin
      if (!trial[W]) begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = rsh;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      if (r_r[W-1]) begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    qn_r <= qn_nxt;
    rn_r <= rn_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign ctl.start = start;
  assign ctl.done = done_r;
  assign quot = qn_r ? (~q_r + 1'b1) : q_r;
  assign rem = rn_r ? (~r_r + 1'b1) : r_r;
endmodule

// File: rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: products, Euclid loop and final reduction.
`timescale 1ns / 1ps
// How long one item takes depends on its kind and on the number of Euclid steps: the cross
// products use a shift-and-add multiplier (up to three products), and each Euclid
// remainder step and each of the two final divisions uses the shared bit-serial divider;
// when both parts are zero, no division is done. Busy is high from the accepted start
// until out_valid.
// The result is shown for one cycle on out_valid and cannot be held off.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic        out_valid,
  output logic signed [31:0] out_res_num,
  output logic signed [31:0] out_res_den,
  output logic        out_status
);
  localparam int W = WORD_BITS;
  localparam int CW = $clog2(W + 1);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_GCD  = 4'd2;
  localparam logic [3:0] S_GWT  = 4'd3;
  localparam logic [3:0] S_DN   = 4'd4;
  localparam logic [3:0] S_DNW  = 4'd5;
  localparam logic [3:0] S_DD   = 4'd6;
  localparam logic [3:0] S_DDW  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] st_r, st_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [W-1:0] an_r, an_nxt, ad_r, ad_nxt, bn_r, bn_nxt, bd_r, bd_nxt;
  logic [W-1:0] num_r, num_nxt, den_r, den_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [W-1:0] acc_r, acc_nxt, mc_r, mc_nxt, mp_r, mp_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] rn_r, rn_nxt, rd_r, rd_nxt;
  logic stat_r, stat_nxt, ov_r, ov_nxt;
  logic dv_start;
  logic [W-1:0] dv_a, dv_b, dv_q, dv_r;
  rau_ctl_t dv_ctl;
  logic reduce_k;

  function automatic logic [W-1:0] sx(input logic [31:0] v);
    return W'($signed(v));
  endfunction

  function automatic logic [31:0] lo32(input logic [W-1:0] v);
    return 32'($signed(v));
  endfunction

  assign reduce_k = !(kind_r == KIND_ADD || kind_r == KIND_SUB ||
                      kind_r == KIND_MUL || kind_r == KIND_DIV);

  rau_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .ctl(dv_ctl), .quot(dv_q), .rem(dv_r)
  );

  always_comb begin
    st_nxt = st_r;
    kind_nxt = kind_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    num_nxt = num_r; den_nxt = den_r; x_nxt = x_r; y_nxt = y_r;
    acc_nxt = acc_r; mc_nxt = mc_r; mp_nxt = mp_r;
    ph_nxt = ph_r; cnt_nxt = cnt_r;
    rn_nxt = rn_r; rd_nxt = rd_r; stat_nxt = stat_r;
    ov_nxt = 1'b0;
    dv_start = 1'b0;
    dv_a = x_r;
    dv_b = y_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          an_nxt = sx(in_a_num); ad_nxt = sx(in_a_den);
          bn_nxt = sx(in_b_num); bd_nxt = sx(in_b_den);
          acc_nxt = '0; cnt_nxt = '0; ph_nxt = 2'd0;
          mc_nxt = sx(in_a_den);
          mp_nxt = (in_kind == KIND_DIV) ? sx(in_b_num) : sx(in_b_den);
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (reduce_k) begin
          num_nxt = (kind_r == KIND_RCP) ? ad_r : an_r;
          den_nxt = (kind_r == KIND_RCP) ? an_r : ad_r;
          x_nxt = an_r; y_nxt = ad_r;
          st_nxt = S_GCD;
        end else begin
          if (mp_r[0]) acc_nxt = acc_r + mc_r;
          mc_nxt = {mc_r[W-2:0], 1'b0};
          mp_nxt = {1'b0, mp_r[W-1:1]};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(W - 1)) begin
            cnt_nxt = '0;
            acc_nxt = '0;
            priority case (ph_r)
              2'd0: begin
                den_nxt = mp_r[0] ? acc_r + mc_r : acc_r;
                mc_nxt = an_r;
                mp_nxt = (kind_r == KIND_MUL) ? bn_r : bd_r;
                ph_nxt = 2'd1;
              end
              2'd1: begin
                num_nxt = mp_r[0] ? acc_r + mc_r : acc_r;
                mc_nxt = bn_r;
                mp_nxt = ad_r;
                ph_nxt = 2'd2;
                if (kind_r == KIND_MUL || kind_r == KIND_DIV) begin
                  x_nxt = mp_r[0] ? acc_r + mc_r : acc_r;
                  y_nxt = den_r;
                  st_nxt = S_GCD;
                end
              end
              default: begin
                num_nxt = (kind_r == KIND_ADD) ?
                          num_r + (mp_r[0] ? acc_r + mc_r : acc_r) :
                          num_r - (mp_r[0] ? acc_r + mc_r : acc_r);
                x_nxt = num_nxt; y_nxt = den_r;
                st_nxt = S_GCD;
              end
            endcase
          end
        end
      end
      S_GCD: begin
        if (y_r == '0) begin
          if (x_r == '0) begin
            stat_nxt = 1'b1;
            rn_nxt = lo32(num_r); rd_nxt = lo32(den_r);
            st_nxt = S_OUT;
          end else begin
            st_nxt = S_DN;
          end
        end else begin
          dv_start = 1'b1;
          st_nxt = S_GWT;
        end
      end
      S_GWT: begin
        if (dv_ctl.done) begin
          x_nxt = y_r;
          y_nxt = dv_r;
          st_nxt = S_GCD;
        end
      end
      S_DN: begin
        dv_start = 1'b1; dv_a = num_r; dv_b = x_r;
        st_nxt = S_DNW;
      end
      S_DNW: begin
        if (dv_ctl.done) begin
          rn_nxt = lo32(dv_q);
          st_nxt = S_DD;
        end
      end
      S_DD: begin
        dv_start = 1'b1; dv_a = den_r; dv_b = x_r;
        st_nxt = S_DDW;
      end
      S_DDW: begin
        if (dv_ctl.done) begin
          rd_nxt = lo32(dv_q);
          stat_nxt = 1'b0;
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    num_r <= num_nxt; den_r <= den_nxt; x_r <= x_nxt; y_r <= y_nxt;
    acc_r <= acc_nxt; mc_r <= mc_nxt; mp_r <= mp_nxt;
    ph_r <= ph_nxt; cnt_r <= cnt_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; stat_r <= stat_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_res_num = rn_r;
  assign out_res_den = rd_r;
  assign out_status = stat_r;
endmodule

// File: rtl/rau_checker.sv
// Port-level checker for the rational arithmetic unit and its bind statement.
`timescale 1ns / 1ps
module rau_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic signed [31:0] out_res_num,
  input logic signed [31:0] out_res_den,
  input logic out_status
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after transfer");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_res_num == 0 && out_res_den == 0)
    else $error("unreduced result not zero");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_res_num(out_res_num), .out_res_den(out_res_den), .out_status(out_status)
);
